[sv/opep_pkg.sv]
// ----------------------------------------------------------------------------
// opep_pkg
// Shared symbol codes, precedence table and control types of the parser.
// ----------------------------------------------------------------------------
package opep_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned SYM_W = 5;

  // Stack symbol codes (0..15 are token classes)
  localparam logic [SYM_W-1:0] SYM_HASH  = 5'd0;
  localparam logic [SYM_W-1:0] SYM_MUL   = 5'd1;
  localparam logic [SYM_W-1:0] SYM_NEQ   = 5'd12;
  localparam logic [SYM_W-1:0] SYM_LPAR  = 5'd13;
  localparam logic [SYM_W-1:0] SYM_RPAR  = 5'd14;
  localparam logic [SYM_W-1:0] SYM_OPND  = 5'd15;
  localparam logic [SYM_W-1:0] SYM_BOT   = 5'd16;
  localparam logic [SYM_W-1:0] SYM_E     = 5'd17;
  localparam logic [SYM_W-1:0] SYM_MARK  = 5'd18;

  // Result status codes
  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_SYNTAX  = 2'd2;
  localparam logic [1:0] ST_OVFL    = 2'd3;

  typedef enum logic [2:0] {
    ACT_SHIFT  = 3'd0,
    ACT_REDUCE = 3'd1,
    ACT_PUSH   = 3'd2,
    ACT_ERROR  = 3'd3,
    ACT_FINISH = 3'd4
  } act_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic       load;
    logic [1:0] rd_k;
    logic       cap_en;
    logic [1:0] cap_k;
    logic       red_commit;
    logic       plan;
    logic       wr_step;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_consumed;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    act_e act;
    logic red_ok;
    logic ovf;
    logic accept;
    logic wr_last;
    logic kind;
  } sts_t;

  function automatic logic [2:0] row_of(input logic [SYM_W-1:0] sym);
    logic [2:0] r;
    if (sym <= 5'd3)       r = 3'd0;
    else if (sym <= 5'd5)  r = 3'd1;
    else if (sym <= 5'd12) r = 3'd2;
    else if (sym == 5'd13) r = 3'd3;
    else if (sym == 5'd14) r = 3'd4;
    else if (sym == 5'd15) r = 3'd5;
    else                   r = 3'd6;
    return r;
  endfunction

  // Precedence table: row of the top terminal, incoming token (0..16)
  function automatic act_e prec(input logic [2:0] row, input logic [SYM_W-1:0] tok);
    act_e a;
    a = ACT_ERROR;
    unique case (row)
      3'd0: begin
        if (tok == SYM_HASH || tok == SYM_LPAR || tok == SYM_OPND) a = ACT_SHIFT;
        else a = ACT_REDUCE;
      end
      3'd1: begin
        if (tok <= 5'd3 || tok == SYM_LPAR || tok == SYM_OPND) a = ACT_SHIFT;
        else a = ACT_REDUCE;
      end
      3'd2: begin
        if (tok <= 5'd6 || tok == SYM_LPAR || tok == SYM_OPND) a = ACT_SHIFT;
        else a = ACT_REDUCE;
      end
      3'd3: begin
        if (tok == SYM_RPAR) a = ACT_PUSH;
        else if (tok == SYM_BOT) a = ACT_ERROR;
        else a = ACT_SHIFT;
      end
      3'd4: begin
        if (tok == SYM_LPAR || tok == SYM_OPND) a = ACT_ERROR;
        else a = ACT_REDUCE;
      end
      3'd5: begin
        if (tok == SYM_HASH || tok == SYM_LPAR) a = ACT_ERROR;
        else if (tok == SYM_OPND) a = ACT_FINISH;
        else a = ACT_REDUCE;
      end
      default: begin
        if (tok == SYM_RPAR || tok == SYM_BOT) a = ACT_ERROR;
        else a = ACT_SHIFT;
      end
    endcase
    return a;
  endfunction

endpackage

[sv/opep_in_if.sv]
// ----------------------------------------------------------------------------
// opep_in_if
// Token request channel: valid/ready with kind and token class.
// ----------------------------------------------------------------------------
interface opep_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] token_class;

  modport source (output valid, kind, token_class, input ready);
  modport sink   (input valid, kind, token_class, output ready);
endinterface

[sv/opep_out_if.sv]
// ----------------------------------------------------------------------------
// opep_out_if
// Result request channel: valid/ready with status and consumed flag.
// ----------------------------------------------------------------------------
interface opep_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       token_consumed;

  modport source (output valid, status, token_consumed, input ready);
  modport sink   (input valid, status, token_consumed, output ready);
endinterface

[sv/operator_precedence_expr_parser_top.sv]
// ----------------------------------------------------------------------------
// operator_precedence_expr_parser_top
// Operator-precedence syntax checker for one expression, one token a request.
// ----------------------------------------------------------------------------
// One request at a time: a token loads the four-entry stack window from the
// single-read stack RAM, takes a table decision, then either writes up to
// three stack entries (shift/push) or loads the window again per reduction,
// and finally presents the result. After a final status (accepted or
// rejected) the stack is back to just the bottom mark, so the next token
// starts a new expression. No clearing pass is needed after reset.
module operator_precedence_expr_parser_top #(
  parameter int unsigned STACK_DEPTH = opep_pkg::STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  opep_in_if.sink    in_i,
  opep_out_if.source out_o
);
  opep_pkg::cmd_t cmd;
  opep_pkg::sts_t sts;

  // Sequencer
  opep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stack, window and match logic; result registers drive the payload
  opep_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (in_i.kind),
    .token_class_i   (in_i.token_class),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (out_o.status),
    .token_consumed_o(out_o.token_consumed)
  );
endmodule

[sv/opep_ram.sv]
// ----------------------------------------------------------------------------
// opep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opep_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/opep_datapath.sv]
// ----------------------------------------------------------------------------
// opep_datapath
// Symbol stack, top-of-stack window, table lookup and handle matching.
// ----------------------------------------------------------------------------
module opep_datapath #(
  parameter int unsigned STACK_DEPTH = opep_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             kind_i,
  input  logic [4:0]       token_class_i,
  input  opep_pkg::cmd_t   cmd_i,
  output opep_pkg::sts_t   sts_o,
  output logic [1:0]       status_o,
  output logic             token_consumed_o
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = AW + 2;
  localparam int unsigned SW = opep_pkg::SYM_W;

  logic [AW-1:0] t_q;
  logic [SW-1:0] tok_q;
  logic          kind_q;
  logic [SW-1:0] w_q [4];
  logic [SW-1:0] rdata;
  logic [1:0]    status_q;
  logic          consumed_q;

  logic [SW-1:0] wsym_q [3];
  logic [AW-1:0] wbase_q, newt_q;
  logic [1:0]    widx_q, wlast_q;

  logic [CW-1:0] t_ext;
  logic [SW-1:0] top_sym, top_term;
  opep_pkg::act_e act;
  logic [1:0]    hk;
  logic          red_ok;
  logic [AW-1:0] m;
  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;

  assign t_ext = CW'(t_q);

  // Topmost terminal: no two E's are ever adjacent, so one skip suffices
  always_comb begin
    top_sym  = (t_q != '0 && w_q[0] == opep_pkg::SYM_E) ? w_q[1] : w_q[0];
    top_term = (top_sym > opep_pkg::SYM_BOT) ? opep_pkg::SYM_OPND : top_sym;
    act      = opep_pkg::prec(opep_pkg::row_of(top_term), tok_q);
  end

  // Handle match: marker must sit one to three entries below the top
  always_comb begin
    hk     = 2'd0;
    red_ok = 1'b0;
    if (w_q[0] != opep_pkg::SYM_MARK) begin
      if (w_q[1] == opep_pkg::SYM_MARK) hk = 2'd1;
      else if (w_q[2] == opep_pkg::SYM_MARK) hk = 2'd2;
      else if (w_q[3] == opep_pkg::SYM_MARK) hk = 2'd3;
    end
    case (hk)
      2'd1: red_ok = (w_q[0] == opep_pkg::SYM_OPND);
      2'd2: red_ok = (w_q[1] == opep_pkg::SYM_HASH) && (w_q[0] == opep_pkg::SYM_E);
      2'd3: red_ok = ((w_q[2] == opep_pkg::SYM_LPAR) && (w_q[1] == opep_pkg::SYM_E) &&
                      (w_q[0] == opep_pkg::SYM_RPAR)) ||
                     ((w_q[2] == opep_pkg::SYM_E) && (w_q[0] == opep_pkg::SYM_E) &&
                      (w_q[1] >= opep_pkg::SYM_MUL) && (w_q[1] <= opep_pkg::SYM_NEQ));
      default: red_ok = 1'b0;
    endcase
    m = t_q - AW'(hk);
  end

  always_comb begin
    sts_o.act     = act;
    sts_o.red_ok  = red_ok;
    sts_o.ovf     = (act == opep_pkg::ACT_PUSH) ? (t_ext + CW'(1) > CW'(STACK_DEPTH - 1))
                                                : (t_ext + CW'(2) > CW'(STACK_DEPTH - 1));
    sts_o.accept  = (t_q == AW'(1)) && (w_q[0] == opep_pkg::SYM_E);
    sts_o.wr_last = (widx_q == wlast_q);
    sts_o.kind    = kind_q;
  end

  assign we    = cmd_i.red_commit | cmd_i.wr_step;
  assign waddr = cmd_i.red_commit ? m : (wbase_q + AW'(widx_q));
  assign wdata = cmd_i.red_commit ? opep_pkg::SYM_E : wsym_q[widx_q];

  opep_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(t_q - AW'(cmd_i.rd_k)),
    .rdata_o(rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q    <= '0;
      widx_q <= '0;
    end else begin
      if (cmd_i.red_commit) t_q <= m;
      if (cmd_i.plan) widx_q <= '0;
      else if (cmd_i.wr_step) begin
        widx_q <= widx_q + 2'd1;
        if (widx_q == wlast_q) t_q <= newt_q;
      end
      if (cmd_i.res_set && cmd_i.res_status != opep_pkg::ST_PARSING) t_q <= '0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      tok_q  <= (token_class_i > opep_pkg::SYM_BOT) ? opep_pkg::SYM_OPND : token_class_i;
    end
    if (cmd_i.cap_en) begin
      // index zero is the bottom mark, never stored
      w_q[cmd_i.cap_k] <= (t_ext <= CW'(cmd_i.cap_k)) ? opep_pkg::SYM_BOT : rdata;
    end
    if (cmd_i.plan) begin
      newt_q <= t_q + ((act == opep_pkg::ACT_PUSH) ? AW'(1) : AW'(2));
      if (act == opep_pkg::ACT_PUSH) begin
        wbase_q   <= t_q + AW'(1);
        wsym_q[0] <= tok_q;
        wsym_q[1] <= tok_q;
        wsym_q[2] <= tok_q;
        wlast_q   <= 2'd0;
      end else if (t_q != '0 && w_q[0] == opep_pkg::SYM_E) begin
        wbase_q   <= t_q;
        wsym_q[0] <= opep_pkg::SYM_MARK;
        wsym_q[1] <= opep_pkg::SYM_E;
        wsym_q[2] <= tok_q;
        wlast_q   <= 2'd2;
      end else begin
        wbase_q   <= t_q + AW'(1);
        wsym_q[0] <= opep_pkg::SYM_MARK;
        wsym_q[1] <= tok_q;
        wsym_q[2] <= tok_q;
        wlast_q   <= 2'd1;
      end
    end
    if (cmd_i.res_set) begin
      status_q   <= cmd_i.res_status;
      consumed_q <= cmd_i.res_consumed;
    end
  end

  assign status_o         = status_q;
  assign token_consumed_o = consumed_q;
endmodule

[sv/opep_ctrl.sv]
// ----------------------------------------------------------------------------
// opep_ctrl
// Sequencer: window fetch, table decision, stack writes, result handoff.
// ----------------------------------------------------------------------------
module opep_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  opep_pkg::sts_t sts_i,
  output opep_pkg::cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic       fin_q, fin_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        // each read is captured in the cycle after it is issued
        cmd_o.rd_k   = k_q[1:0];
        cmd_o.cap_en = (k_q != 3'd0);
        cmd_o.cap_k  = 2'(k_q - 3'd1);
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (fin_q || sts_i.kind) begin
          if (sts_i.red_ok) begin
            cmd_o.red_commit = 1'b1;
            fin_d   = 1'b1;
            k_d     = '0;
            state_d = S_FETCH;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = sts_i.accept ? opep_pkg::ST_ACCEPT : opep_pkg::ST_SYNTAX;
            state_d = S_OUT;
          end
        end else begin
          unique case (sts_i.act)
            opep_pkg::ACT_SHIFT, opep_pkg::ACT_PUSH: begin
              if (sts_i.ovf) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = opep_pkg::ST_OVFL;
                state_d = S_OUT;
              end else begin
                cmd_o.plan = 1'b1;
                state_d    = S_WRITE;
              end
            end
            opep_pkg::ACT_REDUCE: begin
              if (sts_i.red_ok) begin
                cmd_o.red_commit = 1'b1;
                k_d     = '0;
                state_d = S_FETCH;
              end else begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = opep_pkg::ST_SYNTAX;
                state_d = S_OUT;
              end
            end
            opep_pkg::ACT_FINISH: begin
              fin_d = 1'b1;
            end
            default: begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = opep_pkg::ST_SYNTAX;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.wr_last) begin
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = opep_pkg::ST_PARSING;
          cmd_o.res_consumed = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        fin_d = 1'b0;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      fin_q   <= fin_d;
    end
  end
endmodule
